// ----- hdl/sscc_pkg.sv -----
// shared types and constants for the strip-chart column store
`timescale 1ns / 1ps

package sscc_pkg;

  localparam int WIDTH_DEFAULT = 128;

  localparam int SAMPLE_W   = 16;
  localparam int PAGE_W     = 3;
  localparam int COL_W      = 7;
  localparam int BYTE_W     = 8;
  localparam int LEVEL_W    = 6;
  localparam int ROW_COUNT  = 48;
  localparam int PAGE_COUNT = 6;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(ROW_COUNT - 1);

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } sscc_state_t;

  typedef struct packed {
    logic append;   // write new column, advance pointer
    logic capture;  // latch read slot and page
    logic mem_rd;   // read the column memory
    logic load;     // load output byte register
  } sscc_cmd_t;

endpackage

// ----- hdl/sscc_ctrl.sv -----
// controller state machine for the strip-chart column store
`timescale 1ns / 1ps

module sscc_ctrl
  import sscc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_func,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output sscc_cmd_t cmd
);

  sscc_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        accept;

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_func == FUNC_READ)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.append  = 1'b0;
    cmd.capture = 1'b0;
    cmd.mem_rd  = 1'b0;
    cmd.load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.append  = accept && (in_func == FUNC_APPEND);
        cmd.capture = accept && (in_func == FUNC_READ);
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hdl/sscc_dp.sv -----
// datapath: column builder, circular column memory and page byte select
`timescale 1ns / 1ps

module sscc_dp
  import sscc_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sscc_cmd_t           cmd,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic [PAGE_W-1:0]   in_page,
  input  logic [COL_W-1:0]    in_column,
  output logic [BYTE_W-1:0]   out_read_byte
);

  localparam int PW = $clog2(WIDTH);
  localparam int FW = PW + 1;
  localparam int SW = ((PW > COL_W) ? PW : COL_W) + 1;

  localparam logic [ROW_COUNT-1:0] ONES = {ROW_COUNT{1'b1}};

  logic [ROW_COUNT-1:0] mem [WIDTH];

  logic [PW-1:0]        ptr_r, ptr_nxt;
  logic [FW-1:0]        fill_r, fill_nxt;
  logic [LEVEL_W-1:0]   prev_r, prev_nxt;
  logic [PW-1:0]        slot_r;
  logic [PAGE_W-1:0]    page_r;
  logic                 hit_r;
  logic [ROW_COUNT-1:0] rdata_r;
  logic [BYTE_W-1:0]    byte_r;

  logic [LEVEL_W-1:0]   level;
  logic [LEVEL_W-1:0]   lo_lvl, hi_lvl;
  logic [ROW_COUNT-1:0] new_col;
  logic [SW-1:0]        sum;
  logic [PW-1:0]        slot;
  logic                 col_ok;
  logic                 written;
  logic [BYTE_W-1:0]    sel_byte;

  // clamp sample to 0..47
  always_comb begin
    if (in_sample[SAMPLE_W-1]) begin
      level = '0;
    end else if (in_sample > SAMPLE_W'(LEVEL_MAX)) begin
      level = LEVEL_MAX;
    end else begin
      level = in_sample[LEVEL_W-1:0];
    end
  end

  // rows 47-hi .. 47-lo are set
  always_comb begin
    lo_lvl  = (level < prev_r) ? level : prev_r;
    hi_lvl  = (level < prev_r) ? prev_r : level;
    new_col = (ONES >> lo_lvl) & (ONES << (LEVEL_MAX - hi_lvl));
  end

  // slot = (oldest + column) mod WIDTH
  always_comb begin
    sum = {{(SW-PW){1'b0}}, ptr_r} + {{(SW-COL_W){1'b0}}, in_column};
    if (sum >= SW'(WIDTH)) begin
      slot = PW'(sum - SW'(WIDTH));
    end else begin
      slot = sum[PW-1:0];
    end
    col_ok  = {{(SW-COL_W){1'b0}}, in_column} < SW'(WIDTH);
    written = {1'b0, slot} < fill_r;
  end

  always_comb begin
    ptr_nxt  = ptr_r;
    fill_nxt = fill_r;
    prev_nxt = prev_r;
    if (cmd.append) begin
      ptr_nxt  = (ptr_r == PW'(WIDTH - 1)) ? '0 : ptr_r + 1'b1;
      fill_nxt = (fill_r == FW'(WIDTH)) ? fill_r : fill_r + 1'b1;
      prev_nxt = level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      fill_r <= '0;
      prev_r <= '0;
    end else begin
      ptr_r  <= ptr_nxt;
      fill_r <= fill_nxt;
      prev_r <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[ptr_r] <= new_col;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      slot_r <= slot;
      page_r <= in_page;
      hit_r  <= col_ok && written;
    end
  end

  always_comb begin
    case (page_r)
      3'd0:    sel_byte = rdata_r[0*BYTE_W +: BYTE_W];
      3'd1:    sel_byte = rdata_r[1*BYTE_W +: BYTE_W];
      3'd2:    sel_byte = rdata_r[2*BYTE_W +: BYTE_W];
      3'd3:    sel_byte = rdata_r[3*BYTE_W +: BYTE_W];
      3'd4:    sel_byte = rdata_r[4*BYTE_W +: BYTE_W];
      3'd5:    sel_byte = rdata_r[5*BYTE_W +: BYTE_W];
      default: sel_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= hit_r ? sel_byte : '0;
    end
  end

  assign out_read_byte = byte_r;

endmodule

// ----- hdl/scrolling_strip_chart_columns_unit.sv -----
// top level of the scrolling strip-chart column store
`timescale 1ns / 1ps

// Frame store for a 48-row strip chart, WIDTH columns of six 8-row pages.
// Input channel (in_valid/in_ready): in_func selects the operation.
//   append (in_func = 0): in_sample is clamped to 0..47, a bar column from
//     the previous level to the new one is written over the oldest column,
//     which makes it the newest; the transfer gives no result.
//   read (in_func = 1): returns the page byte of in_page at in_column,
//     column 0 the oldest; pages beyond 5 or columns at or past WIDTH give 0.
// Output channel (out_valid/out_ready): one transfer per read.
// Read path: slot compute, registered memory read, byte select into the
//   output register.
// Throughput: one append per cycle while the input is open; a new read is
//   taken only after the previous read has loaded the output register.
// Stall: the output register holds a result until taken; the input side,
//   appends included, stays closed meanwhile, and any transfer is accepted
//   once the output register is empty or being emptied in the same cycle.
// Reset (rst_n, synchronous): pointer, previous level and fill count go to
//   zero; columns not yet written read as zero through the fill count, so
//   there is no clearing pass and the block is ready right after reset.

module scrolling_strip_chart_columns_unit
  import sscc_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic [PAGE_W-1:0]   in_page,
  input  logic [COL_W-1:0]    in_column,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [BYTE_W-1:0]   out_read_byte
);

  sscc_cmd_t cmd;

  // sequencing of appends and three-step reads
  sscc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // column builder, circular store and byte select
  sscc_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_sample     (in_sample),
    .in_page       (in_page),
    .in_column     (in_column),
    .out_read_byte (out_read_byte)
  );

  // a read keeps the input side closed while it is in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_func == FUNC_READ)) |=> !in_ready)
    else $error("input accepted while a read is in flight");

  // every read shows its result once it has passed the read and load states
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_func == FUNC_READ)) |-> ##3 out_valid)
    else $error("read result missing three cycles after transfer");

  // a result only appears for a read taken before the read and load states
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_func == FUNC_READ), 3))
    else $error("result without a matching read");

endmodule
